// File: rtl/apc_pkg.sv
`timescale 1ns / 1ps

package apc_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned QUO_BITS = 8;
    localparam int unsigned REM_W    = 2 * PIX_W;
    localparam int unsigned DSH_W    = PIX_W + QUO_BITS - 1;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_HALF = 8'd127;

    typedef enum logic [1:0] {
        CFG_DIRECTION     = 2'd0,
        CFG_ALPHA_PRESENT = 2'd1,
        CFG_SRC_PREMUL    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                        direction;
        logic                        alpha_present;
        logic                        src_premul;
    } t_cfg;

    typedef struct packed {
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        logic [NUM_CH-1:0][PIX_W-1:0] quo;
        logic [DSH_W-1:0]             dsh;
        logic [NUM_CH-1:0]            use_fix;
        logic [NUM_CH-1:0][PIX_W-1:0] fix;
        logic [PIX_W-1:0]             alpha;
    } t_cell_data;

endpackage

// File: rtl/alpha_premultiply_converter_top.sv
// Throughput: one pixel per cycle while i_stall is low, set by a front stage and
// eight division cells, each of which resolves one quotient bit for all three colors.
// Each stage moves on when its successor has room, so bubbles close up under stall.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps

module alpha_premultiply_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_red,
    input  logic [7:0] i_in_green,
    input  logic [7:0] i_in_blue,
    input  logic [7:0] i_in_alpha,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);
    import apc_pkg::*;

    t_cfg                         r_cfg;
    logic [NUM_CH-1:0][PIX_W-1:0] color_in;
    logic [NUM_CH-1:0][PIX_W-1:0] color_out;
    logic                         prep_ready;
    logic [QUO_BITS:0]            stg_valid;
    logic [QUO_BITS:0]            stg_ready;
    t_cell_data                   stg_data [QUO_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= 1'b0;
            r_cfg.alpha_present <= 1'b1;
            r_cfg.src_premul    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIRECTION:     r_cfg.direction     <= i_cfg_data;
                CFG_ALPHA_PRESENT: r_cfg.alpha_present <= i_cfg_data;
                CFG_SRC_PREMUL:    r_cfg.src_premul    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign color_in = {i_in_blue, i_in_green, i_in_red};
    assign o_stall  = !prep_ready;

    apc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_color (color_in),
        .i_alpha (i_in_alpha),
        .o_ready (prep_ready),
        .o_valid (stg_valid[0]),
        .o_data  (stg_data[0]),
        .i_ready (stg_ready[0])
    );

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
        apc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_ready (stg_ready[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1]),
            .i_ready (stg_ready[k+1])
        );
    end

    assign stg_ready[QUO_BITS] = !i_stall;
    assign o_valid             = stg_valid[QUO_BITS];

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            color_out[i] = stg_data[QUO_BITS].use_fix[i] ? stg_data[QUO_BITS].fix[i]
                                                         : stg_data[QUO_BITS].quo[i];
        end
    end

    assign o_out_red   = color_out[0];
    assign o_out_green = color_out[1];
    assign o_out_blue  = color_out[2];
    assign o_out_alpha = stg_data[QUO_BITS].alpha;

endmodule

// File: rtl/apc_prep.sv
`timescale 1ns / 1ps

module apc_prep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  apc_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  logic [apc_pkg::NUM_CH-1:0][apc_pkg::PIX_W-1:0] i_color,
    input  logic [apc_pkg::PIX_W-1:0] i_alpha,
    output logic                      o_ready,
    output logic                      o_valid,
    output apc_pkg::t_cell_data       o_data,
    input  logic                      i_ready
);
    import apc_pkg::*;

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [PIX_W-1:0] a_eff;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        a_eff = (!i_cfg.direction && !i_cfg.alpha_present) ? PIX_MAX : i_alpha;
        n_data       = '0;
        n_data.alpha = a_eff;
        n_data.dsh   = i_cfg.direction ? {a_eff, {(QUO_BITS-1){1'b0}}}
                                       : {PIX_MAX, {(QUO_BITS-1){1'b0}}};
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_cfg.direction) begin
                n_data.rem[i] = (REM_W'(i_color[i]) << PIX_W) - REM_W'(i_color[i])
                              + REM_W'(a_eff >> 1);
            end else begin
                n_data.rem[i] = REM_W'(i_color[i]) * REM_W'(a_eff) + REM_W'(PIX_HALF);
            end
            if (a_eff == '0) begin
                n_data.use_fix[i] = 1'b1;
                n_data.fix[i]     = '0;
            end else if (a_eff == PIX_MAX || (!i_cfg.direction && i_cfg.src_premul)) begin
                n_data.use_fix[i] = 1'b1;
                n_data.fix[i]     = i_color[i];
            end else if (i_cfg.direction && i_color[i] >= a_eff) begin
                n_data.use_fix[i] = 1'b1;
                n_data.fix[i]     = PIX_MAX;
            end else begin
                n_data.use_fix[i] = 1'b0;
                n_data.fix[i]     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/apc_div_cell.sv
`timescale 1ns / 1ps

module apc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  apc_pkg::t_cell_data i_data,
    output logic                o_ready,
    output logic                o_valid,
    output apc_pkg::t_cell_data o_data,
    input  logic                i_ready
);
    import apc_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // One restoring division step per lane; the divisor shifts down one bit per cell.
    always_comb begin
        n_data     = i_data;
        n_data.dsh = i_data.dsh >> 1;
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_data.rem[i] >= REM_W'(i_data.dsh)) begin
                n_data.rem[i] = i_data.rem[i] - REM_W'(i_data.dsh);
                n_data.quo[i] = {i_data.quo[i][PIX_W-2:0], 1'b1};
            end else begin
                n_data.quo[i] = {i_data.quo[i][PIX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
